>>> rtl/numfc_pkg.sv
// Shared type codes, stream field positions and pipeline types for the format converter.
`default_nettype none

package numfc_pkg;

    // Number format codes carried in source_type and target_type.
    localparam logic [3:0] TY_F32  = 4'd0;
    localparam logic [3:0] TY_F64  = 4'd1;
    localparam logic [3:0] TY_I8   = 4'd2;
    localparam logic [3:0] TY_I32  = 4'd3;
    localparam logic [3:0] TY_I64  = 4'd4;
    localparam logic [3:0] TY_BOOL = 4'd5;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 72;

    // Result request layout on m_tdata.
    localparam int OUT_OK_BIT  = 64;
    localparam int OUT_OVF_BIT = 65;
    localparam int OUT_PAD_LSB = 66;

    // Per-request information that travels alongside the magnitude.
    typedef struct packed {
        logic        ok;
        logic [3:0]  tt;
        logic        sign;
        logic        nan;
        logic        inf;
        logic [51:0] pay;
    } meta_t;

endpackage

`default_nettype wire

>>> rtl/numeric_format_converter_core.sv
// Five-stage pipelined converter between float32, float64, int8, int32, int64 and bool.
// Throughput: one request per cycle while m_tready does not stall the output stage.
// Stages: decode, leading-zero count, normalise, align with sticky, round and pack.
// Each stage has its own valid bit and moves when the stage after it can take a request,
// so bubbles are squeezed out and a stall at m_tready loses nothing.
// aresetn is synchronous and active low; it clears all valid bits, data is not reset.
`default_nettype none

module numeric_format_converter_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // s_tdata from bit 0: source_type[3:0], target_type[7:4], value_bits[71:8]
    input  wire logic [71:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // m_tdata from bit 0: result_bits[63:0], ok[64], overflow[65], zero pad[71:66]
    output logic [71:0]      m_tdata
);

    function automatic logic [5:0] lzc64(input logic [63:0] m);
        logic [5:0] n;
        n = 6'd0;
        for (int i = 0; i < 64; i++) begin
            if (m[i]) begin
                n = 6'(63 - i);
            end
        end
        return n;
    endfunction

    // Right shift with the shifted-out bits folded into a sticky bit (bit 0 of the result).
    function automatic logic [64:0] shr_sticky(input logic [63:0] m, input logic [12:0] a);
        logic [63:0] lost_mask;
        lost_mask = ~({64{1'b1}} << a[5:0]);
        if (a >= 13'd64) begin
            return {64'd0, |m};
        end
        return {m >> a[5:0], |(m & lost_mask)};
    endfunction

    logic en1, en2, en3, en4, en5;

    // Stage 1: decode into sign, magnitude and exponent, value = mag * 2^(exp-63).
    logic [3:0]         st_in, tt_in;
    logic [63:0]        v_in;
    numfc_pkg::meta_t   d1_meta;
    logic [63:0]        d1_mag;
    logic signed [12:0] d1_exp;
    logic [7:0]         a8;
    logic [31:0]        a32;

    logic               r1_v_reg;
    numfc_pkg::meta_t   r1_meta_reg;
    logic [63:0]        r1_mag_reg;
    logic signed [12:0] r1_exp_reg;

    assign st_in = s_tdata[3:0];
    assign tt_in = s_tdata[7:4];
    assign v_in  = s_tdata[71:8];
    assign a8    = v_in[7] ? (~v_in[7:0] + 8'd1) : v_in[7:0];
    assign a32   = v_in[31] ? (~v_in[31:0] + 32'd1) : v_in[31:0];

    always_comb begin
        d1_meta      = '0;
        d1_mag       = 64'd0;
        d1_exp       = 13'sd63;
        d1_meta.ok   = (st_in <= numfc_pkg::TY_BOOL) && (tt_in <= numfc_pkg::TY_BOOL);
        d1_meta.tt   = tt_in;
        unique case (st_in)
            numfc_pkg::TY_F32: begin
                d1_meta.sign = v_in[31];
                if (v_in[30:23] == 8'hFF) begin
                    d1_meta.nan = (v_in[22:0] != 23'd0);
                    d1_meta.inf = (v_in[22:0] == 23'd0);
                    d1_meta.pay = {v_in[22:0], 29'd0};
                end else if (v_in[30:23] == 8'd0) begin
                    d1_mag = {1'b0, v_in[22:0], 40'd0};
                    d1_exp = -13'sd126;
                end else begin
                    d1_mag = {1'b1, v_in[22:0], 40'd0};
                    d1_exp = $signed({5'd0, v_in[30:23]}) - 13'sd127;
                end
            end
            numfc_pkg::TY_F64: begin
                d1_meta.sign = v_in[63];
                if (v_in[62:52] == 11'h7FF) begin
                    d1_meta.nan = (v_in[51:0] != 52'd0);
                    d1_meta.inf = (v_in[51:0] == 52'd0);
                    d1_meta.pay = v_in[51:0];
                end else if (v_in[62:52] == 11'd0) begin
                    d1_mag = {1'b0, v_in[51:0], 11'd0};
                    d1_exp = -13'sd1022;
                end else begin
                    d1_mag = {1'b1, v_in[51:0], 11'd0};
                    d1_exp = $signed({2'd0, v_in[62:52]}) - 13'sd1023;
                end
            end
            numfc_pkg::TY_I8: begin
                d1_meta.sign = v_in[7];
                d1_mag       = {56'd0, a8};
            end
            numfc_pkg::TY_I32: begin
                d1_meta.sign = v_in[31];
                d1_mag       = {32'd0, a32};
            end
            numfc_pkg::TY_I64: begin
                d1_meta.sign = v_in[63];
                d1_mag       = v_in[63] ? (~v_in + 64'd1) : v_in;
            end
            numfc_pkg::TY_BOOL: begin
                d1_mag = {63'd0, v_in[0]};
            end
            default: begin
                d1_mag = 64'd0;
            end
        endcase
    end

    // Stage 2: leading-zero count.
    logic               r2_v_reg;
    numfc_pkg::meta_t   r2_meta_reg;
    logic [63:0]        r2_mag_reg;
    logic signed [12:0] r2_exp_reg;
    logic [5:0]         r2_lz_reg;
    logic               r2_zero_reg;

    // Stage 3: normalised so that bit 63 is set for any nonzero value.
    logic               r3_v_reg;
    numfc_pkg::meta_t   r3_meta_reg;
    logic [63:0]        r3_mag_reg;
    logic signed [12:0] r3_exp_reg;
    logic               r3_zero_reg;

    // Stage 4: alignment for both float widths and the truncated integer.
    logic [12:0]        sh32, sh64;
    logic [64:0]        al32, al64;
    logic [63:0]        trunc_c;

    logic               r4_v_reg;
    numfc_pkg::meta_t   r4_meta_reg;
    logic               r4_zero_reg;
    logic [23:0]        r4_k32_reg;
    logic               r4_g32_reg, r4_s32_reg, r4_big32_reg;
    logic [7:0]         r4_eb32_reg;
    logic [52:0]        r4_k64_reg;
    logic               r4_g64_reg, r4_s64_reg, r4_big64_reg;
    logic [10:0]        r4_eb64_reg;
    logic [63:0]        r4_t_reg;
    logic               r4_tbig_reg;

    assign sh32 = (r3_exp_reg < -13'sd126) ? 13'(-13'sd126 - r3_exp_reg) : 13'd0;
    assign sh64 = (r3_exp_reg < -13'sd1022) ? 13'(-13'sd1022 - r3_exp_reg) : 13'd0;
    assign al32 = shr_sticky(r3_mag_reg, sh32);
    assign al64 = shr_sticky(r3_mag_reg, sh64);
    assign trunc_c = (r3_exp_reg < 13'sd0 || r3_exp_reg > 13'sd63) ? 64'd0
                   : (r3_mag_reg >> (~r3_exp_reg[5:0]));

    // Stage 5: round to nearest even, saturate, pack.
    logic [30:0] sum32;
    logic [62:0] sum64;
    logic        rnd32, rnd64;
    logic [63:0] hi_c, lim_c, mask_c, ival_c, res_c;
    logic        sat_c, ovf_c;

    logic        r5_v_reg;
    logic [63:0] r5_res_reg;
    logic        r5_ok_reg, r5_ovf_reg;

    assign rnd32 = r4_g32_reg & (r4_s32_reg | r4_k32_reg[0]);
    assign rnd64 = r4_g64_reg & (r4_s64_reg | r4_k64_reg[0]);
    assign sum32 = {r4_eb32_reg, 23'd0} + {7'd0, r4_k32_reg} + {30'd0, rnd32};
    assign sum64 = {r4_eb64_reg, 52'd0} + {10'd0, r4_k64_reg} + {62'd0, rnd64};

    always_comb begin
        unique case (r4_meta_reg.tt)
            numfc_pkg::TY_I8: begin
                hi_c   = 64'h0000_0000_0000_007F;
                mask_c = 64'h0000_0000_0000_00FF;
            end
            numfc_pkg::TY_I32: begin
                hi_c   = 64'h0000_0000_7FFF_FFFF;
                mask_c = 64'h0000_0000_FFFF_FFFF;
            end
            default: begin
                hi_c   = 64'h7FFF_FFFF_FFFF_FFFF;
                mask_c = 64'hFFFF_FFFF_FFFF_FFFF;
            end
        endcase
        // The negative limit's magnitude is one more than the positive one, and its pattern
        // before masking is the same value.
        lim_c  = hi_c + {63'd0, r4_meta_reg.sign};
        sat_c  = r4_meta_reg.inf | r4_tbig_reg | (r4_t_reg > lim_c);
        ival_c = sat_c ? lim_c : (r4_meta_reg.sign ? (~r4_t_reg + 64'd1) : r4_t_reg);

        res_c = 64'd0;
        ovf_c = 1'b0;
        unique case (r4_meta_reg.tt)
            numfc_pkg::TY_F32: begin
                if (r4_meta_reg.nan) begin
                    res_c = {32'd0, r4_meta_reg.sign, 8'hFF, 1'b1, r4_meta_reg.pay[50:29]};
                end else if (r4_meta_reg.inf || r4_big32_reg) begin
                    res_c = {32'd0, r4_meta_reg.sign, 8'hFF, 23'd0};
                end else if (r4_zero_reg) begin
                    res_c = {32'd0, r4_meta_reg.sign, 31'd0};
                end else begin
                    res_c = {32'd0, r4_meta_reg.sign, sum32};
                end
            end
            numfc_pkg::TY_F64: begin
                if (r4_meta_reg.nan) begin
                    res_c = {r4_meta_reg.sign, 11'h7FF, 1'b1, r4_meta_reg.pay[50:0]};
                end else if (r4_meta_reg.inf || r4_big64_reg) begin
                    res_c = {r4_meta_reg.sign, 11'h7FF, 52'd0};
                end else if (r4_zero_reg) begin
                    res_c = {r4_meta_reg.sign, 63'd0};
                end else begin
                    res_c = {r4_meta_reg.sign, sum64};
                end
            end
            numfc_pkg::TY_BOOL: begin
                res_c = {63'd0, r4_meta_reg.nan | ~r4_zero_reg};
            end
            numfc_pkg::TY_I8, numfc_pkg::TY_I32, numfc_pkg::TY_I64: begin
                if (r4_meta_reg.nan) begin
                    ovf_c = 1'b1;
                end else begin
                    res_c = ival_c & mask_c;
                    ovf_c = sat_c;
                end
            end
            default: begin
                res_c = 64'd0;
            end
        endcase
        if (!r4_meta_reg.ok) begin
            res_c = 64'd0;
            ovf_c = 1'b0;
        end
    end

    // A stage moves when it is empty or the stage after it moves.
    assign en5      = ~r5_v_reg | m_tready;
    assign en4      = ~r4_v_reg | en5;
    assign en3      = ~r3_v_reg | en4;
    assign en2      = ~r2_v_reg | en3;
    assign en1      = ~r1_v_reg | en2;
    assign s_tready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r1_v_reg <= 1'b0;
            r2_v_reg <= 1'b0;
            r3_v_reg <= 1'b0;
            r4_v_reg <= 1'b0;
            r5_v_reg <= 1'b0;
        end else begin
            if (en1) r1_v_reg <= s_tvalid;
            if (en2) r2_v_reg <= r1_v_reg;
            if (en3) r3_v_reg <= r2_v_reg;
            if (en4) r4_v_reg <= r3_v_reg;
            if (en5) r5_v_reg <= r4_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            r1_meta_reg <= d1_meta;
            r1_mag_reg  <= d1_mag;
            r1_exp_reg  <= d1_exp;
        end
        if (en2) begin
            r2_meta_reg <= r1_meta_reg;
            r2_mag_reg  <= r1_mag_reg;
            r2_exp_reg  <= r1_exp_reg;
            r2_lz_reg   <= lzc64(r1_mag_reg);
            r2_zero_reg <= (r1_mag_reg == 64'd0) & ~r1_meta_reg.nan & ~r1_meta_reg.inf;
        end
        if (en3) begin
            r3_meta_reg <= r2_meta_reg;
            r3_mag_reg  <= r2_mag_reg << r2_lz_reg;
            r3_exp_reg  <= r2_exp_reg - $signed({7'd0, r2_lz_reg});
            r3_zero_reg <= r2_zero_reg;
        end
        if (en4) begin
            r4_meta_reg  <= r3_meta_reg;
            r4_zero_reg  <= r3_zero_reg;
            r4_k32_reg   <= al32[64:41];
            r4_g32_reg   <= al32[40];
            r4_s32_reg   <= |al32[39:0];
            r4_eb32_reg  <= (r3_exp_reg >= -13'sd126) ? 8'(r3_exp_reg + 13'sd126) : 8'd0;
            r4_big32_reg <= (r3_exp_reg > 13'sd127);
            r4_k64_reg   <= al64[64:12];
            r4_g64_reg   <= al64[11];
            r4_s64_reg   <= |al64[10:0];
            r4_eb64_reg  <= (r3_exp_reg >= -13'sd1022) ? 11'(r3_exp_reg + 13'sd1022) : 11'd0;
            r4_big64_reg <= (r3_exp_reg > 13'sd1023);
            r4_t_reg     <= trunc_c;
            r4_tbig_reg  <= (r3_exp_reg > 13'sd63);
        end
        if (en5) begin
            r5_res_reg <= res_c;
            r5_ok_reg  <= r4_meta_reg.ok;
            r5_ovf_reg <= ovf_c;
        end
    end

    assign m_tvalid = r5_v_reg;
    assign m_tdata  = {6'd0, r5_ovf_reg, r5_ok_reg, r5_res_reg};

endmodule

`default_nettype wire

>>> rtl/numfc_checker.sv
// Port-level checker for the format converter and its bind to the top level.
`default_nettype none

module numfc_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [71:0] m_tdata
);

    // A stalled result request keeps its data.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result request changed while stalled");

    // With the output register empty the pipeline can always take a request.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty output");

    // An unsupported type gives a clean zero result.
    a_unsup: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[numfc_pkg::OUT_OK_BIT] |->
            m_tdata[63:0] == 64'd0 && !m_tdata[numfc_pkg::OUT_OVF_BIT])
        else $error("unsupported type with nonzero result");

    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[71:numfc_pkg::OUT_PAD_LSB] == '0)
        else $error("padding bits set");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind numeric_format_converter_core numfc_checker u_numfc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

>>> sim/tb_top.sv
// Self-checking testbench for the numeric format converter core.
`timescale 1ns / 100ps
`default_nettype none

module tb_top;

    localparam logic [3:0] TY_F32  = numfc_pkg::TY_F32;
    localparam logic [3:0] TY_F64  = numfc_pkg::TY_F64;
    localparam logic [3:0] TY_I8   = numfc_pkg::TY_I8;
    localparam logic [3:0] TY_I32  = numfc_pkg::TY_I32;
    localparam logic [3:0] TY_I64  = numfc_pkg::TY_I64;
    localparam logic [3:0] TY_BOOL = numfc_pkg::TY_BOOL;
    localparam int OUT_OK_BIT      = numfc_pkg::OUT_OK_BIT;
    localparam int OUT_OVF_BIT     = numfc_pkg::OUT_OVF_BIT;

    localparam int RANDOM_ITEMS = 630;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 12;

    typedef struct {
        logic [63:0] res;
        logic        ok;
        logic        ovf;
    } conv_result_t;

    typedef struct {
        logic [3:0]  st;
        logic [3:0]  tt;
        logic [63:0] v;
        bit          typed;
        logic [63:0] res;
        logic        ok;
        logic        ovf;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;

    conv_result_t pending_results[$];
    int  error_count = 0;
    int  sent_count = 0;
    int  checked_count = 0;
    int  cycle_count = 0;
    bit  calm = 1'b0;

    numeric_format_converter_core u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Round a value sgn * mag * 2^e once, to nearest even, into float32 or float64.
    function automatic logic [63:0] round_to_float(input logic sgn, input logic [63:0] mag,
                                                   input int e, input bit dbl);
        int p, prec, bias, emin, q, shift, biased;
        logic [127:0] m, wide, low_mask;
        logic rbit, sticky;
        prec = dbl ? 53 : 24;
        bias = dbl ? 1023 : 127;
        emin = 1 - bias;
        p = 0;
        rbit = 1'b0;
        sticky = 1'b0;
        if (mag == 64'd0) begin
            return dbl ? {sgn, 63'd0} : {32'd0, sgn, 31'd0};
        end
        for (int i = 0; i < 64; i++) begin
            if (mag[i]) p = i;
        end
        q = ((p + e) < emin ? emin : (p + e)) - (prec - 1);
        shift = q - e;
        wide = {64'd0, mag};
        if (shift <= 0) begin
            m = wide << (-shift);
        end else if (shift >= 66) begin
            m = '0;
            sticky = 1'b1;
        end else begin
            m = wide >> shift;
            rbit = wide[shift - 1];
            low_mask = (128'd1 << (shift - 1)) - 128'd1;
            sticky = |(wide & low_mask);
        end
        if (rbit && (sticky || m[0])) m = m + 128'd1;
        if (m == (128'd1 << prec)) begin
            m = m >> 1;
            q = q + 1;
        end
        biased = m[prec - 1] ? (q + prec - 1 + bias) : 0;
        if (biased >= 2 * bias + 1) begin
            return dbl ? {sgn, 11'h7FF, 52'd0} : {32'd0, sgn, 8'hFF, 23'd0};
        end
        if (dbl) return {sgn, biased[10:0], m[51:0]};
        return {32'd0, sgn, biased[7:0], m[22:0]};
    endfunction

    function automatic conv_result_t convert_value(input logic [3:0] st, input logic [3:0] tt,
                                                   input logic [63:0] v);
        conv_result_t r;
        logic sgn, is_flt, is_nan, is_inf, huge;
        logic [63:0] mag, iv, mask;
        logic [51:0] pay;
        logic [127:0] trunc, limit, signed_val;
        int e, p, nbits;
        r = '{res: 64'd0, ok: 1'b0, ovf: 1'b0};
        sgn = 1'b0; is_flt = 1'b0; is_nan = 1'b0; is_inf = 1'b0; huge = 1'b0;
        mag = '0; iv = '0; pay = '0; e = 0; p = 0;
        if (st > TY_BOOL || tt > TY_BOOL) return r;
        r.ok = 1'b1;

        case (st)
            TY_F32: begin
                is_flt = 1'b1;
                sgn = v[31];
                if (v[30:23] == 8'hFF) begin
                    is_nan = v[22:0] != 0;
                    is_inf = v[22:0] == 0;
                    pay = {v[22:0], 29'd0};
                end else if (v[30:23] == 8'd0) begin
                    mag = {41'd0, v[22:0]};
                    e = -149;
                end else begin
                    mag = {40'd0, 1'b1, v[22:0]};
                    e = int'(v[30:23]) - 150;
                end
            end
            TY_F64: begin
                is_flt = 1'b1;
                sgn = v[63];
                if (v[62:52] == 11'h7FF) begin
                    is_nan = v[51:0] != 0;
                    is_inf = v[51:0] == 0;
                    pay = v[51:0];
                end else if (v[62:52] == 11'd0) begin
                    mag = {12'd0, v[51:0]};
                    e = -1074;
                end else begin
                    mag = {11'd0, 1'b1, v[51:0]};
                    e = int'(v[62:52]) - 1075;
                end
            end
            TY_I8:   iv = {{56{v[7]}}, v[7:0]};
            TY_I32:  iv = {{32{v[31]}}, v[31:0]};
            TY_I64:  iv = v;
            default: iv = {63'd0, v[0]};
        endcase
        if (!is_flt) begin
            sgn = iv[63];
            mag = sgn ? -iv : iv;
        end

        if (tt == TY_F32 || tt == TY_F64) begin
            if (is_nan) begin
                pay[51] = 1'b1;
                r.res = (tt == TY_F32) ? {32'd0, sgn, 8'hFF, pay[51:29]}
                                       : {sgn, 11'h7FF, pay};
            end else if (is_inf) begin
                r.res = (tt == TY_F32) ? {32'd0, sgn, 8'hFF, 23'd0} : {sgn, 11'h7FF, 52'd0};
            end else begin
                r.res = round_to_float(sgn, mag, e, tt == TY_F64);
            end
        end else if (tt == TY_BOOL) begin
            r.res = (is_nan || is_inf || mag != 0) ? 64'd1 : 64'd0;
        end else begin
            nbits = (tt == TY_I8) ? 8 : (tt == TY_I32) ? 32 : 64;
            mask = (nbits == 64) ? '1 : ((64'd1 << nbits) - 64'd1);
            limit = 128'd1 << (nbits - 1);
            for (int i = 0; i < 64; i++) begin
                if (mag[i]) p = i;
            end
            trunc = '0;
            if (e >= 0) begin
                if (mag != 0 && p + e >= 64) huge = 1'b1;
                else trunc = {64'd0, mag} << e;
            end else if (-e < 64) begin
                trunc = {64'd0, mag} >> (-e);
            end
            if (is_nan) begin
                r.res = 64'd0;
                r.ovf = 1'b1;
            end else if (!sgn && (is_inf || huge || trunc >= limit)) begin
                r.res = (limit[63:0] - 64'd1) & mask;
                r.ovf = 1'b1;
            end else if (sgn && (is_inf || huge || trunc > limit)) begin
                signed_val = -limit;
                r.res = signed_val[63:0] & mask;
                r.ovf = 1'b1;
            end else begin
                signed_val = sgn ? -trunc : trunc;
                r.res = signed_val[63:0] & mask;
            end
        end
        return r;
    endfunction

    function automatic logic [63:0] random_value(input logic [3:0] st);
        logic [63:0] v;
        logic [10:0] ex;
        v = {$urandom, $urandom};
        case (st)
            TY_F32: begin
                case ($urandom_range(0, 5))
                    0: v[30:23] = 8'd0;
                    1: v[30:23] = 8'hFF;
                    2: v[30:23] = 8'($urandom_range(100, 170));
                    3: v[30:23] = 8'($urandom_range(120, 135));
                    default: ;
                endcase
                if ($urandom_range(0, 3) == 0) v[22:0] = '0;
            end
            TY_F64: begin
                ex = v[62:52];
                case ($urandom_range(0, 6))
                    0: ex = 11'd0;
                    1: ex = 11'h7FF;
                    2: ex = 11'($urandom_range(1000, 1090));
                    3: ex = 11'($urandom_range(860, 1160));
                    4: ex = 11'($urandom_range(1015, 1030));
                    default: ;
                endcase
                v[62:52] = ex;
                case ($urandom_range(0, 3))
                    0: v[51:0] = '0;
                    1: v[28:0] = '0;
                    default: ;
                endcase
            end
            TY_I8, TY_I32, TY_I64: begin
                case ($urandom_range(0, 3))
                    0: v = 64'($signed($urandom_range(0, 300)) - 150);
                    1: v = {$urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0, $urandom};
                    default: ;
                endcase
            end
            default: ;
        endcase
        return v;
    endfunction

    // Hands one request to the block and books its expected result once it is taken.
    task automatic send_request(input logic [3:0] st, input logic [3:0] tt,
                                input logic [63:0] v, input conv_result_t want);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {v, tt, st};
        forever begin
            @(negedge aclk);
            if (s_tready) break;
        end
        @(posedge aclk);
        pending_results.push_back(want);
        sent_count++;
    endtask

    stim_row_t directed[] = '{
        '{4'd6,    TY_F32,  64'hFFFF_FFFF_FFFF_FFFF, 1, 64'd0, 1'b0, 1'b0},
        '{TY_F32,  4'd15,   64'h3F80_0000,           1, 64'd0, 1'b0, 1'b0},
        '{TY_I8,   TY_I32,  64'h80,                  1, 64'hFFFF_FF80, 1'b1, 1'b0},
        '{TY_I64,  TY_I8,   64'h8000_0000_0000_0000, 1, 64'h80, 1'b1, 1'b1},
        '{TY_I64,  TY_I32,  64'h7FFF_FFFF_FFFF_FFFF, 1, 64'h7FFF_FFFF, 1'b1, 1'b1},
        '{TY_F32,  TY_I32,  64'h7F80_0000,           1, 64'h7FFF_FFFF, 1'b1, 1'b1},
        '{TY_F32,  TY_I8,   64'hFF80_0000,           1, 64'h80, 1'b1, 1'b1},
        '{TY_F32,  TY_I64,  64'h7F80_0001,           1, 64'd0, 1'b1, 1'b1},
        '{TY_F32,  TY_BOOL, 64'h7F80_0001,           1, 64'd1, 1'b1, 1'b0},
        '{TY_F32,  TY_BOOL, 64'h8000_0000,           1, 64'd0, 1'b1, 1'b0},
        '{TY_F32,  TY_F32,  64'hFF80_0001,           1, 64'hFFC0_0001, 1'b1, 1'b0},
        '{TY_F64,  TY_F64,  64'h7FF0_0000_0000_0001, 1, 64'h7FF8_0000_0000_0001, 1'b1, 1'b0},
        '{TY_F64,  TY_F32,  64'h7E37_E43C_8800_759C, 1, 64'h7F80_0000, 1'b1, 1'b0},
        '{TY_BOOL, TY_I32,  64'hFFFF_FFFF_FFFF_FFFE, 1, 64'd0, 1'b1, 1'b0},
        '{TY_BOOL, TY_F32,  64'hFFFF_FFFF_FFFF_FFFF, 1, 64'h3F80_0000, 1'b1, 1'b0},
        '{TY_I64,  TY_F64,  64'h7FFF_FFFF_FFFF_FFFF, 1, 64'h43E0_0000_0000_0000, 1'b1, 1'b0},
        '{TY_I32,  TY_F32,  64'h0100_0001,           0, 64'd0, 1'b0, 1'b0},
        '{TY_F64,  TY_F32,  64'h0000_0000_0000_0001, 1, 64'd0, 1'b1, 1'b0},
        '{TY_F64,  TY_I8,   64'hC004_0000_0000_0000, 0, 64'd0, 1'b0, 1'b0},
        '{TY_F32,  TY_F64,  64'h3F80_0000,           1, 64'h3FF0_0000_0000_0000, 1'b1, 1'b0},
        '{TY_F64,  TY_I8,   64'hC060_2000_0000_0000, 1, 64'h80, 1'b1, 1'b1},
        '{TY_F64,  TY_I8,   64'hC060_1CCC_CCCC_CCCD, 0, 64'd0, 1'b0, 1'b0},
        '{TY_F32,  TY_I32,  64'h4F00_0000,           1, 64'h7FFF_FFFF, 1'b1, 1'b1},
        '{TY_F32,  TY_F64,  64'h0000_0001,           0, 64'd0, 1'b0, 1'b0},
        '{TY_I64,  TY_BOOL, 64'hFFFF_FFFF_FFFF_FFFF, 1, 64'd1, 1'b1, 1'b0},
        '{TY_F64,  TY_F32,  64'h47EF_FFFF_F000_0000, 0, 64'd0, 1'b0, 1'b0}
    };

    initial begin
        conv_result_t want;
        logic [3:0] st, tt;
        logic [63:0] v;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) begin
            if (directed[i].typed)
                want = '{res: directed[i].res, ok: directed[i].ok, ovf: directed[i].ovf};
            else
                want = convert_value(directed[i].st, directed[i].tt, directed[i].v);
            send_request(directed[i].st, directed[i].tt, directed[i].v, want);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // Every so often both sides run without gaps for a stretch.
            calm = (n % 100) < 15;
            if ($urandom_range(0, 15) == 0) begin
                st = 4'($urandom);
                tt = 4'($urandom);
            end else begin
                st = 4'($urandom_range(0, 5));
                tt = 4'($urandom_range(0, 5));
            end
            v = random_value(st);
            send_request(st, tt, v, convert_value(st, tt, v));
        end
        s_tvalid <= 1'b0;
        calm = 1'b0;

        wait (pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Sent %0d requests (directed corner cases and random conversions),", sent_count);
        $display("checked %0d results with %0d mismatches.", checked_count, error_count);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Result side: random back-pressure, one hold-off per result.
    initial begin
        int stall;
        @(posedge aclk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            forever begin
                @(negedge aclk);
                if (m_tvalid) break;
            end
            @(posedge aclk);
        end
    end

    // Values on both sides are steady at the falling edge, so the check samples there.
    always @(negedge aclk) begin
        conv_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, m_tdata);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                checked_count++;
                if (m_tdata[63:0] !== want.res) begin
                    $display("%0t: result_bits expected %h actual %h", $time, want.res,
                             m_tdata[63:0]);
                    error_count++;
                end
                if (m_tdata[OUT_OK_BIT] !== want.ok) begin
                    $display("%0t: ok expected %b actual %b", $time, want.ok,
                             m_tdata[OUT_OK_BIT]);
                    error_count++;
                end
                if (m_tdata[OUT_OVF_BIT] !== want.ovf) begin
                    $display("%0t: overflow expected %b actual %b", $time, want.ovf,
                             m_tdata[OUT_OVF_BIT]);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out with %0d results outstanding.", pending_results.size());
            $display("FAIL");
            $finish;
        end
    end

endmodule

`default_nettype wire
